/* hw/rtl/ssfr_pkg.sv */
// shared types and constants for the sync/sum frame receiver
// no dependencies
`default_nettype none

package ssfr_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned PosW        = 3;
  localparam int unsigned PayloadN    = 5;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned OutDataW    = 32;

  localparam logic [ByteW-1:0] SyncByte     = 8'hFF;
  localparam logic [ByteW-1:0] AddrReset    = 8'hFE;
  localparam logic [PosW-1:0]  SumPos       = 3'd6;
  localparam logic [PosW-1:0]  FirstPos     = 3'd1;

  localparam logic [CfgIdxW-1:0] RegAcceptAddr = 1'd0;
  localparam logic [CfgIdxW-1:0] RegCsumEnable = 1'd1;

  localparam logic StatusOk       = 1'b0;
  localparam logic StatusCsumErr  = 1'b1;

  typedef struct packed {
    logic             valid;
    logic             status;
    logic [ByteW-1:0] command_byte;
    logic [ByteW-1:0] data_low;
    logic [ByteW-1:0] data_high;
    logic [ByteW-1:0] extra_byte;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/ssfr_decoder.sv */
// frame state machine: sync hunt, byte capture, running sum and checksum test
// depends on ssfr_pkg
`default_nettype none

module ssfr_decoder import ssfr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [ByteW-1:0] rx_byte_i,
  input  wire logic             idle_timeout_i,
  input  wire logic [ByteW-1:0] accept_address_i,
  input  wire logic             checksum_enable_i,
  output result_t               result_o
);

  logic             in_frame_q, in_frame_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] bytes_q [PayloadN];
  logic             store;
  logic [PosW-1:0]  store_idx;
  logic             sum_ok;

  assign store     = step_i && !idle_timeout_i && in_frame_q && (pos_q != SumPos);
  assign store_idx = pos_q - FirstPos;
  assign sum_ok    = (rx_byte_i == sum_q) || !checksum_enable_i;

  always_comb begin
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    sum_d      = sum_q;
    result_o   = '0;
    if (step_i) begin
      if (idle_timeout_i) begin
        in_frame_d = 1'b0;
        pos_d      = '0;
        sum_d      = '0;
      end else if (!in_frame_q) begin
        if (rx_byte_i == SyncByte) begin
          in_frame_d = 1'b1;
          pos_d      = FirstPos;
          sum_d      = '0;
        end
      end else if (pos_q != SumPos) begin
        sum_d = sum_q + rx_byte_i;
        pos_d = pos_q + FirstPos;
      end else begin
        in_frame_d = 1'b0;
        pos_d      = '0;
        sum_d      = '0;
        if (!sum_ok) begin
          result_o.valid  = 1'b1;
          result_o.status = StatusCsumErr;
        end else if (bytes_q[0] == accept_address_i) begin
          result_o.valid        = 1'b1;
          result_o.status       = StatusOk;
          result_o.command_byte = bytes_q[1];
          result_o.data_low     = bytes_q[2];
          result_o.data_high    = bytes_q[3];
          result_o.extra_byte   = bytes_q[4];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      sum_q      <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      sum_q      <= sum_d;
    end
  end

  for (genvar i = 0; i < PayloadN; i++) begin : g_bytes
    always_ff @(posedge clk_i) begin
      if (store && (store_idx == PosW'(i))) begin
        bytes_q[i] <= rx_byte_i;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sync_sum_frame_receiver.sv */
// top level: input register, configuration registers, decoder, output register
// path: input register, decoder, output register; one byte per cycle unless the output stalls
// a stalled output holds the result and the input stage, back-pressure reaches s_axis_tready
// reset: hunting for sync, accept_address 0xFE, checksum check on; captured bytes not cleared
// depends on ssfr_pkg and ssfr_decoder
`default_nettype none

module sync_sum_frame_receiver import ssfr_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ByteW-1:0]    cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [ByteW-1:0]    s_axis_tdata,   // rx_byte
  input  wire logic                s_axis_tuser,   // idle_timeout
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [OutDataW-1:0] m_axis_tdata,   // command_byte, data_low, data_high, extra_byte
  output      logic                m_axis_tuser    // frame_status
);

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_timeout_q;
  logic             out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic             out_status_q;
  logic [ByteW-1:0] accept_address_q;
  logic             checksum_enable_q;
  logic             advance;
  logic             step;
  result_t          result;

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accept_address_q  <= AddrReset;
      checksum_enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegAcceptAddr: accept_address_q  <= cfg_data_i;
        RegCsumEnable: checksum_enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q    <= s_axis_tdata;
      in_timeout_q <= s_axis_tuser;
    end
  end

  ssfr_decoder u_decoder (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (step),
    .rx_byte_i         (in_byte_q),
    .idle_timeout_i    (in_timeout_q),
    .accept_address_i  (accept_address_q),
    .checksum_enable_i (checksum_enable_q),
    .result_o          (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= result.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result.valid) begin
      out_status_q <= result.status;
      out_data_q   <= {result.extra_byte, result.data_high,
                       result.data_low, result.command_byte};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

endmodule

`default_nettype wire

/* tb/sv/ssfr_checker.sv */
// checker for the sync/sum frame receiver: watches the register port and both streams,
// predicts each decoded frame result and compares it with the dut output
// depends on ssfr_pkg
`default_nettype none

module ssfr_checker import ssfr_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ByteW-1:0]    cfg_data_i,
  input  wire logic                s_axis_tvalid,
  input  wire logic                s_axis_tready,
  input  wire logic [ByteW-1:0]    s_axis_tdata,   // rx_byte
  input  wire logic                s_axis_tuser,   // idle_timeout
  input  wire logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  input  wire logic [OutDataW-1:0] m_axis_tdata,   // command_byte, data_low, data_high, extra_byte
  input  wire logic                m_axis_tuser,   // frame_status
  output      int                  pending_o,
  output      int                  fail_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             status;
    logic [ByteW-1:0] command_byte;
    logic [ByteW-1:0] data_low;
    logic [ByteW-1:0] data_high;
    logic [ByteW-1:0] extra_byte;
  } frame_result_t;

  frame_result_t    frame_results_q[$];
  logic [ByteW-1:0] accept_addr;
  logic             csum_on;
  logic             synced;
  logic [PosW-1:0]  frame_pos;
  logic [ByteW-1:0] frame_buf[PayloadN];
  logic [ByteW-1:0] frame_sum;
  int               fail_count;

  task automatic report_mismatch(input string what);
    if (fail_count < 20) begin
      $display("%0t ns: mismatch: %s", $realtime, what);
    end
    fail_count++;
  endtask

  task automatic decode_rx_byte(input logic [ByteW-1:0] rx, input logic timeout);
    frame_result_t res;
    logic          sum_good;
    if (timeout) begin
      synced    = 1'b0;
      frame_pos = '0;
      frame_sum = '0;
    end else if (!synced) begin
      if (rx == SyncByte) begin
        synced    = 1'b1;
        frame_pos = FirstPos;
        frame_sum = '0;
      end
    end else if (frame_pos >= FirstPos && frame_pos < SumPos) begin
      frame_buf[frame_pos - FirstPos] = rx;
      frame_sum = frame_sum + rx;
      frame_pos = frame_pos + 1'b1;
    end else begin
      sum_good  = (rx == frame_sum) || !csum_on;
      synced    = 1'b0;
      frame_pos = '0;
      frame_sum = '0;
      if (!sum_good) begin
        res = '{status: StatusCsumErr, default: '0};
        frame_results_q.push_back(res);
      end else if (frame_buf[0] == accept_addr) begin
        res = '{status: StatusOk, command_byte: frame_buf[1], data_low: frame_buf[2],
                data_high: frame_buf[3], extra_byte: frame_buf[4]};
        frame_results_q.push_back(res);
      end
    end
  endtask

  task automatic compare_result();
    frame_result_t    want;
    logic [ByteW-1:0] got_b[4];
    logic [ByteW-1:0] want_b[4];
    string            names[4];
    if (frame_results_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result tdata=%h tuser=%b",
                                m_axis_tdata, m_axis_tuser));
      return;
    end
    want   = frame_results_q.pop_front();
    got_b  = '{m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
               m_axis_tdata[31:24]};
    want_b = '{want.command_byte, want.data_low, want.data_high, want.extra_byte};
    names  = '{"command_byte", "data_low", "data_high", "extra_byte"};
    if (m_axis_tuser !== want.status) begin
      report_mismatch($sformatf("frame_status got %b want %b", m_axis_tuser, want.status));
    end
    foreach (got_b[i]) begin
      if (got_b[i] !== want_b[i]) begin
        report_mismatch($sformatf("%s got %h want %h", names[i], got_b[i], want_b[i]));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_results_q.delete();
      accept_addr = AddrReset;
      csum_on     = 1'b1;
      synced      = 1'b0;
      frame_pos   = '0;
      frame_sum   = '0;
      fail_count  = 0;
      pending_o  <= 0;
      fail_o     <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegAcceptAddr) begin
          accept_addr = cfg_data_i;
        end else if (cfg_idx_i == RegCsumEnable) begin
          csum_on = cfg_data_i[0];
        end
      end
      // result first: a byte taken at this edge cannot produce output yet
      if (m_axis_tvalid && m_axis_tready) begin
        compare_result();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decode_rx_byte(s_axis_tdata, s_axis_tuser);
      end
      pending_o <= frame_results_q.size();
      fail_o    <= fail_count;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/tb_sync_sum_frame_receiver.sv */
// testbench top for the sync/sum frame receiver: clock, reset, register writes,
// directed and random byte streams with random gaps and output stalls
// depends on ssfr_pkg, sync_sum_frame_receiver and ssfr_checker
`default_nettype none

module tb_sync_sum_frame_receiver import ssfr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [ByteW-1:0]    cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata;   // rx_byte
  logic                s_axis_tuser;   // idle_timeout
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // command_byte, data_low, data_high, extra_byte
  logic                m_axis_tuser;   // frame_status
  int                  pending;
  int                  fail_count;

  logic [ByteW-1:0]    cur_addr;
  bit                  no_gaps;
  int                  stream_items;

  sync_sum_frame_receiver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  ssfr_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .pending_o     (pending),
    .fail_o        (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver back-pressure: stretches with and without stalls
  initial begin
    int stretch_left;
    int stall_left;
    bit stalls_on;
    int r;
    m_axis_tready = 1'b0;
    stretch_left  = 0;
    stall_left    = 0;
    stalls_on     = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(20, 200);
        stalls_on    = ($urandom_range(0, 99) < 70);
      end
      stretch_left--;
      if (!stalls_on) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          m_axis_tready <= 1'b1;
        end else begin
          stall_left = (r < 92) ? $urandom_range(0, 2) : $urandom_range(9, 39);
          m_axis_tready <= 1'b0;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [ByteW-1:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      return 8'h00;
    end else if (r < 24) begin
      return 8'hFF;
    end
    return ByteW'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] rx, input logic timeout);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx;
    s_axis_tuser  <= timeout;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // cut: frame byte position replaced by a timeout, 0 for a complete frame
  task automatic send_frame(input logic [ByteW-1:0] addr, input logic [ByteW-1:0] cmd,
                            input logic [ByteW-1:0] d0, input logic [ByteW-1:0] d1,
                            input logic [ByteW-1:0] d2, input bit bad_sum, input int cut);
    logic [ByteW-1:0] body[6];
    logic [ByteW-1:0] sum;
    sum = addr + cmd + d0 + d1 + d2;
    if (bad_sum) begin
      sum = sum ^ ByteW'($urandom_range(1, 255));
    end
    body = '{addr, cmd, d0, d1, d2, sum};
    send_byte(SyncByte, 1'b0);
    stream_items++;
    foreach (body[i]) begin
      stream_items++;
      if (cut == i + 1) begin
        send_byte(ByteW'($urandom_range(0, 255)), 1'b1);
        return;
      end
      send_byte(body[i], 1'b0);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [ByteW-1:0] addr, input logic csum_en);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegAcceptAddr;
    cfg_data_i <= addr;
    @(posedge clk_i);
    cfg_idx_i  <= RegCsumEnable;
    cfg_data_i <= {7'($urandom_range(0, 127)), csum_en};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_addr    = addr;
  endtask

  task automatic random_traffic(input int n_items);
    int               goal;
    int               r;
    logic [ByteW-1:0] addr;
    goal = stream_items + n_items;
    while (stream_items < goal) begin
      if ($urandom_range(0, 99) < 15) begin
        no_gaps = !no_gaps;
      end
      r = $urandom_range(0, 99);
      if (r < 20) begin
        repeat ($urandom_range(1, 3)) send_byte(ByteW'($urandom_range(0, 254)), 1'b0);
      end else if (r < 25) begin
        send_byte(pick_byte(), 1'b1);
        stream_items++;
      end
      addr = ($urandom_range(0, 99) < 75) ? cur_addr : pick_byte();
      send_frame(addr, pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                 $urandom_range(0, 99) < 20,
                 ($urandom_range(0, 99) < 8) ? $urandom_range(1, 6) : 0);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = RegAcceptAddr;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cur_addr      = AddrReset;
    no_gaps       = 1'b0;
    stream_items  = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // good frame with extreme payload, bad sum for another address,
    // abandoned frame, noise while hunting, good frame for another address
    send_frame(AddrReset, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0, 0);
    send_frame(8'h12, 8'hFF, 8'h01, 8'h80, 8'h7F, 1'b1, 0);
    send_frame(8'h12, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 2);
    send_byte(8'h00, 1'b0);
    send_frame(8'hFF, 8'h55, 8'hAA, 8'hFF, 8'hFF, 1'b0, 0);

    random_traffic(150);
    set_config(8'h00, 1'b1);
    random_traffic(170);
    set_config(8'hFF, 1'b0);
    random_traffic(170);
    set_config(ByteW'($urandom_range(0, 255)), 1'b0);
    random_traffic(170);
    set_config(ByteW'($urandom_range(0, 255)), 1'b1);
    random_traffic(170);

    drain();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/ssfr_pkg.sv
hw/rtl/ssfr_decoder.sv
hw/rtl/sync_sum_frame_receiver.sv
tb/sv/ssfr_checker.sv
tb/sv/tb_sync_sum_frame_receiver.sv
